@@ sv/rsa_pkg.sv @@
// Shared package for the RGB saturation adjuster.
// Holds the channel width, arithmetic widths and constants, and the payload and stage types.
// No dependencies.
package rsa_pkg;

	// Channel width and largest channel value.
	localparam int CHANNEL_BITS = 8;
	localparam int CH_MAX       = (1 << CHANNEL_BITS) - 1;

	// Percentage handling.
	localparam int PCT_W    = 7;
	localparam int PCT_FULL = 100;
	localparam int SN_FULL  = 9999;
	localparam int SN_W     = 14;

	// Positive path: k = D * sn over the divisor 2 * sd.
	localparam int DEN_W = 8;
	localparam int K_W   = CHANNEL_BITS + SN_W;

	// Negative path: blend sum and division by 100 through a reciprocal.
	localparam int NEG_W = CHANNEL_BITS + PCT_W;
	localparam int NEG_S = CHANNEL_BITS + 14;
	localparam int R_W   = NEG_S - 6;
	localparam int NP_W  = NEG_W + R_W;
	localparam longint unsigned NEG_R = ((64'd1 << NEG_S) + 64'd99) / 64'd100;

	// Configuration port.
	localparam int CFG_DATA_W = 8;

	// Pipeline depth of the front end and of the span stages.
	localparam int FRONT_STAGES = 5;
	localparam int SPAN_STAGES  = 2;

	typedef logic [CHANNEL_BITS-1:0] chan_t;
	typedef logic [PCT_W-1:0] pct_t;

	typedef struct packed {
		chan_t red_in;
		chan_t green_in;
		chan_t blue_in;
		logic  in_region;
	} pix_in_t;

	typedef struct packed {
		chan_t red_out;
		chan_t green_out;
		chan_t blue_out;
	} pix_out_t;

	typedef enum logic [0:0] {
		CFG_SATURATION = 1'b0,
		CFG_MASK       = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_PASS = 2'd0,
		MODE_POS  = 2'd1,
		MODE_NEG  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		CH_RED   = 2'd0,
		CH_GREEN = 2'd1,
		CH_BLUE  = 2'd2
	} chan_idx_t;

	typedef struct packed {
		chan_t     mn;
		chan_t     md;
		chan_t     mx;
		chan_idx_t lo_idx;
		chan_idx_t md_idx;
		chan_idx_t hi_idx;
	} sort_t;

	// Per-pixel data carried alongside the dividers.
	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
		mode_t mode;
		sort_t srt;
		chan_t d;
		logic  ovf;
		chan_t neg_red;
		chan_t neg_green;
		chan_t neg_blue;
	} side_t;

	typedef struct packed {
		side_t            side;
		logic [K_W-1:0]   k;
		logic [DEN_W-1:0] den;
	} front_t;

	typedef struct packed {
		side_t side;
		chan_t nmin;
		chan_t nmax;
	} mid_side_t;

endpackage

@@ sv/rsa_sort.sv @@
// Three-channel ordering for the saturation adjuster: min, middle and max with their channels.
// Depends on rsa_pkg.
module rsa_sort (
	input  rsa_pkg::chan_t c0,
	input  rsa_pkg::chan_t c1,
	input  rsa_pkg::chan_t c2,
	output rsa_pkg::sort_t srt
);
	import rsa_pkg::*;

	// Red and green are compared first; green wins a tie for the max.
	// Blue only displaces the max or min when strictly beyond it.
	always_comb begin
		srt = '0;
		if (c0 > c1) begin
			srt.mx     = c0;
			srt.hi_idx = CH_RED;
			srt.mn     = c1;
			srt.lo_idx = CH_GREEN;
		end else begin
			srt.mx     = c1;
			srt.hi_idx = CH_GREEN;
			srt.mn     = c0;
			srt.lo_idx = CH_RED;
		end
		if (c2 > srt.mx) begin
			srt.md     = srt.mx;
			srt.md_idx = srt.hi_idx;
			srt.mx     = c2;
			srt.hi_idx = CH_BLUE;
		end else if (c2 < srt.mn) begin
			srt.md     = srt.mn;
			srt.md_idx = srt.lo_idx;
			srt.mn     = c2;
			srt.lo_idx = CH_BLUE;
		end else begin
			srt.md     = c2;
			srt.md_idx = CH_BLUE;
		end
	end

endmodule

@@ sv/rsa_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage, with a sideband word kept in step.
// The dividend must be below divisor << QUOT_W for an exact result. Depends on nothing.
module rsa_divider #(
	parameter int DIVIDEND_W = 16,
	parameter int DIVISOR_W  = 8,
	parameter int QUOT_W     = 8,
	parameter int SIDE_W     = 1
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	input  logic [SIDE_W-1:0]     side_in,
	output logic [QUOT_W-1:0]     quotient,
	output logic [DIVIDEND_W-1:0] remainder,
	output logic [SIDE_W-1:0]     side_out
);

	logic [DIVIDEND_W-1:0] rem_s   [QUOT_W];
	logic [DIVIDEND_W-1:0] rem_in  [QUOT_W];
	logic [QUOT_W-1:0]     quot_s  [QUOT_W];
	logic [QUOT_W-1:0]     quot_in [QUOT_W];
	logic [DIVISOR_W-1:0]  dvs_s   [QUOT_W];
	logic [DIVISOR_W-1:0]  dvs_in  [QUOT_W];
	logic [SIDE_W-1:0]     side_s  [QUOT_W];
	logic [SIDE_W-1:0]     side_pv [QUOT_W];

	// The first stage takes the operands; each later stage takes its predecessor.
	assign rem_in[0]  = dividend;
	assign quot_in[0] = '0;
	assign dvs_in[0]  = divisor;
	assign side_pv[0] = side_in;

	for (genvar j = 1; j < QUOT_W; j++) begin : g_link
		assign rem_in[j]  = rem_s[j-1];
		assign quot_in[j] = quot_s[j-1];
		assign dvs_in[j]  = dvs_s[j-1];
		assign side_pv[j] = side_s[j-1];
	end

	// Each stage tries one quotient bit, most significant first.
	for (genvar j = 0; j < QUOT_W; j++) begin : g_step
		localparam int B = QUOT_W - 1 - j;

		logic [DIVIDEND_W-1:0] dvs_sh;
		logic [DIVIDEND_W:0]   diff;
		logic [QUOT_W-1:0]     quot_nx;

		always_comb begin
			dvs_sh     = DIVIDEND_W'(dvs_in[j]) << B;
			diff       = {1'b0, rem_in[j]} - {1'b0, dvs_sh};
			quot_nx    = quot_in[j];
			quot_nx[B] = ~diff[DIVIDEND_W];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= diff[DIVIDEND_W] ? rem_in[j] : diff[DIVIDEND_W-1:0];
				quot_s[j] <= quot_nx;
				dvs_s[j]  <= dvs_in[j];
				side_s[j] <= side_pv[j];
			end
		end
	end

	assign quotient  = quot_s[QUOT_W-1];
	assign remainder = rem_s[QUOT_W-1];
	assign side_out  = side_s[QUOT_W-1];

endmodule

@@ sv/rsa_front.sv @@
// Front end of the saturation adjuster: ordering, mode selection, the spread numerator and
// divisor for the positive path, and the complete blend for the negative path (five stages).
// Depends on rsa_pkg and rsa_sort.
module rsa_front (
	input  logic                                     clk,
	input  logic                                     en,
	input  rsa_pkg::pix_in_t                         pix,
	input  logic signed [rsa_pkg::CFG_DATA_W-1:0]    sat,
	input  logic                                     mask,
	output rsa_pkg::front_t                          fr
);
	import rsa_pkg::*;

	localparam logic signed [CFG_DATA_W-1:0] SAT_HI = CFG_DATA_W'(PCT_FULL);
	localparam logic signed [CFG_DATA_W-1:0] SAT_LO = -SAT_HI;

	sort_t                 srt_c;
	logic [CFG_DATA_W-1:0] abs_c;
	pct_t                  mag_c;
	mode_t                 mode_c;
	logic [CHANNEL_BITS:0] msum_c;

	side_t side_s1, side_s2, side_s3, side_s4, side_s5;
	side_t side_c1, side_c2, side_c3, side_c5;
	pct_t  mag_s1;
	logic  full_s1;
	chan_t m_s1;

	pct_t                 comp_c;
	logic [SN_W-1:0]      sn_c;
	logic [K_W-1:0]       k_s2, k_s3, k_s4, k_s5;
	logic [DEN_W-1:0]     den_s2, den_s3, den_s4, den_s5;
	logic [NEG_W-1:0]     pa_red_s2, pa_green_s2, pa_blue_s2, pm_s2;
	logic [NEG_W-1:0]     n_red_s3, n_green_s3, n_blue_s3;
	logic [NP_W-1:0]      np_red_s4, np_green_s4, np_blue_s4;

	rsa_sort u_sort (
		.c0  (pix.red_in),
		.c1  (pix.green_in),
		.c2  (pix.blue_in),
		.srt (srt_c)
	);

	// Stage 1: clamp the percentage to its range, pick the mode and order the channels.
	always_comb begin
		abs_c = sat[CFG_DATA_W-1] ? CFG_DATA_W'(-sat) : CFG_DATA_W'(sat);
		if (sat > SAT_HI || sat < SAT_LO) begin
			mag_c = PCT_W'(PCT_FULL);
		end else begin
			mag_c = abs_c[PCT_W-1:0];
		end
		if ((mask && !pix.in_region) || sat == '0) begin
			mode_c = MODE_PASS;
		end else if (!sat[CFG_DATA_W-1]) begin
			mode_c = MODE_POS;
		end else begin
			mode_c = MODE_NEG;
		end
		msum_c = {1'b0, srt_c.mn} + {1'b0, srt_c.mx};
		side_c1       = '0;
		side_c1.red   = pix.red_in;
		side_c1.green = pix.green_in;
		side_c1.blue  = pix.blue_in;
		side_c1.mode  = mode_c;
		side_c1.srt   = srt_c;
		side_c1.d     = srt_c.mx - srt_c.mn;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_c1;
			mag_s1  <= mag_c;
			full_s1 <= (mag_c == PCT_W'(PCT_FULL));
			m_s1    <= msum_c[CHANNEL_BITS:1];
		end
	end

	// Stage 2: spread numerator and divisor, and the blend products.
	always_comb begin
		comp_c  = PCT_W'(PCT_FULL) - mag_s1;
		sn_c    = full_s1 ? SN_W'(SN_FULL) : SN_W'(mag_s1);
		side_c2 = side_s1;
		// A grey pixel has no spread to scale and passes as it is.
		if (side_s1.mode == MODE_POS && side_s1.d == '0) begin
			side_c2.mode = MODE_PASS;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2     <= side_c2;
			k_s2        <= K_W'(side_s1.d) * K_W'(sn_c);
			den_s2      <= full_s1 ? DEN_W'(2) : {comp_c, 1'b0};
			pa_red_s2   <= NEG_W'(side_s1.red) * NEG_W'(comp_c);
			pa_green_s2 <= NEG_W'(side_s1.green) * NEG_W'(comp_c);
			pa_blue_s2  <= NEG_W'(side_s1.blue) * NEG_W'(comp_c);
			pm_s2       <= NEG_W'(m_s1) * NEG_W'(mag_s1);
		end
	end

	// Stage 3: blend sums, and whether the spread quotient exceeds the channel range.
	always_comb begin
		side_c3     = side_s2;
		side_c3.ovf = k_s2 >= (K_W'(den_s2) << CHANNEL_BITS);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3     <= side_c3;
			k_s3        <= k_s2;
			den_s3      <= den_s2;
			n_red_s3    <= pa_red_s2 + pm_s2;
			n_green_s3  <= pa_green_s2 + pm_s2;
			n_blue_s3   <= pa_blue_s2 + pm_s2;
		end
	end

	// Stage 4: division by 100 as a multiplication by its scaled reciprocal.
	always_ff @(posedge clk) begin
		if (en) begin
			side_s4     <= side_s3;
			k_s4        <= k_s3;
			den_s4      <= den_s3;
			np_red_s4   <= NP_W'(n_red_s3) * NP_W'(R_W'(NEG_R));
			np_green_s4 <= NP_W'(n_green_s3) * NP_W'(R_W'(NEG_R));
			np_blue_s4  <= NP_W'(n_blue_s3) * NP_W'(R_W'(NEG_R));
		end
	end

	// Stage 5: drop the reciprocal's fraction bits to finish the blend.
	always_comb begin
		side_c5           = side_s4;
		side_c5.neg_red   = np_red_s4[NEG_S +: CHANNEL_BITS];
		side_c5.neg_green = np_green_s4[NEG_S +: CHANNEL_BITS];
		side_c5.neg_blue  = np_blue_s4[NEG_S +: CHANNEL_BITS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side_c5;
			k_s5    <= k_s4;
			den_s5  <= den_s4;
		end
	end

	assign fr.side = side_s5;
	assign fr.k    = k_s5;
	assign fr.den  = den_s5;

endmodule

@@ sv/rsa_span.sv @@
// New span of the positive path: clamped new min and max from the spread quotient, then the
// product that rescales the middle channel (two stages). Depends on rsa_pkg.
module rsa_span (
	input  logic                                  clk,
	input  logic                                  en,
	input  rsa_pkg::side_t                        side,
	input  rsa_pkg::chan_t                        quot,
	input  logic [rsa_pkg::K_W-1:0]               rem,
	output rsa_pkg::mid_side_t                    ms,
	output logic [2*rsa_pkg::CHANNEL_BITS-1:0]    prod
);
	import rsa_pkg::*;

	localparam int Q1_W = CHANNEL_BITS + 1;
	localparam int E2_W = CHANNEL_BITS + 2;

	logic [Q1_W-1:0] qs_c, mn_c, nmin_a_c;
	logic [E2_W-1:0] nmax_a_c, sum_c;
	logic            below_c, round_c, big_c;
	chan_t           nmin_c, nmax_c;

	mid_side_t ms_s1, ms_s2;
	chan_t     off_s1;
	logic [2*CHANNEL_BITS-1:0] prod_s2;

	// Stage 1: the quotient saturates at the channel range, which already forces both clamps.
	always_comb begin
		qs_c     = side.ovf ? {1'b1, {CHANNEL_BITS{1'b0}}} : {1'b0, quot};
		mn_c     = {1'b0, side.srt.mn};
		below_c  = qs_c > mn_c;
		// The lower end truncates toward zero, so a remainder lowers it by one more.
		round_c  = (rem != '0) && (qs_c < mn_c);
		nmin_a_c = mn_c - qs_c - Q1_W'(round_c);
		sum_c    = E2_W'(side.srt.mn) + E2_W'(side.srt.mx);
		nmax_a_c = below_c ? sum_c : E2_W'(side.srt.mx) + E2_W'(qs_c);
		big_c    = nmax_a_c > E2_W'(CH_MAX);
		if (big_c) begin
			nmax_c = chan_t'(CH_MAX);
			nmin_c = (sum_c > E2_W'(CH_MAX)) ? chan_t'(sum_c - E2_W'(CH_MAX)) : '0;
		end else begin
			nmax_c = nmax_a_c[CHANNEL_BITS-1:0];
			nmin_c = below_c ? '0 : nmin_a_c[CHANNEL_BITS-1:0];
		end
		if (nmax_c < nmin_c) begin
			nmax_c = nmin_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ms_s1.side <= side;
			ms_s1.nmin <= nmin_c;
			ms_s1.nmax <= nmax_c;
			off_s1     <= side.srt.md - side.srt.mn;
		end
	end

	// Stage 2: offset of the middle channel times the new span.
	always_ff @(posedge clk) begin
		if (en) begin
			ms_s2   <= ms_s1;
			prod_s2 <= (2*CHANNEL_BITS)'(off_s1) * (2*CHANNEL_BITS)'(ms_s1.nmax - ms_s1.nmin);
		end
	end

	assign ms   = ms_s2;
	assign prod = prod_s2;

endmodule

@@ sv/rgb_saturation_adjust.sv @@
// Top level of the RGB saturation adjuster: configuration registers, pipeline control,
// dividers and the output skid buffer. Depends on rsa_pkg, rsa_front, rsa_divider and rsa_span.
//
// Usage:
// - pix carries one pixel and its region flag; a transfer happens when pix_valid and pix_ready
//   are both high. res carries the adjusted pixel under res_valid and res_ready.
// - cfg_index selects the saturation percentage (signed) or the mask enable; a transfer on the
//   cfg channel writes the register. cfg_ready is always high. Write only while the block is
//   empty.
// - One pixel can be taken every cycle while pix_ready is high. A pixel reaches res through
//   the five front stages, the spread-quotient divider, the two span stages, the middle-channel
//   rescale divider (both dividers one quotient bit per stage) and the output register.
// - All stages advance together. A two-entry output buffer holds results while res_ready is low;
//   pix_ready drops only when both entries are full, so one result may wait while the pipeline
//   still takes pixels, and nothing is lost or repeated.
// - Reset empties the pipeline and the output buffer and clears both registers, so pixels pass
//   unchanged until a saturation value is written.
module rgb_saturation_adjust (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pix_valid,
	output logic                               pix_ready,
	input  rsa_pkg::pix_in_t                   pix,
	output logic                               res_valid,
	input  logic                               res_ready,
	output rsa_pkg::pix_out_t                  res,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  rsa_pkg::cfg_idx_t                  cfg_index,
	input  logic [rsa_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import rsa_pkg::*;

	localparam int NST    = FRONT_STAGES + 2*CHANNEL_BITS + SPAN_STAGES;
	localparam int QSIDE  = $bits(side_t);
	localparam int MSIDE  = $bits(mid_side_t);
	localparam int PROD_W = 2*CHANNEL_BITS;

	logic signed [CFG_DATA_W-1:0] sat_q;
	logic                         mask_q;

	logic           en, push, pop;
	logic [NST-1:0] vld_q;
	logic           spare_v_q;
	pix_out_t       res_q, spare_q, out_d;

	front_t            fr;
	logic [QSIDE-1:0]  qside_vec;
	side_t             qside;
	chan_t             qquot;
	logic [K_W-1:0]    qrem;
	mid_side_t         span_ms;
	logic [PROD_W-1:0] span_prod;
	logic [MSIDE-1:0]  mside_vec;
	mid_side_t         mside;
	chan_t             mquot;
	logic [PROD_W-1:0] mrem;
	logic [CHANNEL_BITS:0] mid_sum;
	chan_t             mid_new;

	function automatic chan_t place(chan_idx_t ch, sort_t s, chan_t lo, chan_t mid, chan_t hi);
		if (s.lo_idx == ch) begin
			return lo;
		end else if (s.hi_idx == ch) begin
			return hi;
		end
		return mid;
	endfunction

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q  <= '0;
			mask_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SATURATION: sat_q  <= cfg_data;
				CFG_MASK:       mask_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The pipeline moves while the output buffer has its spare entry free.
	assign en        = !spare_v_q;
	assign pix_ready = en;
	assign push      = en && vld_q[NST-1];
	assign pop       = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], pix_valid};
		end
	end

	rsa_front u_front (
		.clk  (clk),
		.en   (en),
		.pix  (pix),
		.sat  (sat_q),
		.mask (mask_q),
		.fr   (fr)
	);

	// Spread quotient: k / (2 * sd), needed only up to the channel range.
	rsa_divider #(
		.DIVIDEND_W (K_W),
		.DIVISOR_W  (DEN_W),
		.QUOT_W     (CHANNEL_BITS),
		.SIDE_W     (QSIDE)
	) u_qdiv (
		.clk       (clk),
		.en        (en),
		.dividend  (fr.k),
		.divisor   (fr.den),
		.side_in   (fr.side),
		.quotient  (qquot),
		.remainder (qrem),
		.side_out  (qside_vec)
	);

	assign qside = qside_vec;

	rsa_span u_span (
		.clk  (clk),
		.en   (en),
		.side (qside),
		.quot (qquot),
		.rem  (qrem),
		.ms   (span_ms),
		.prod (span_prod)
	);

	// Middle-channel rescale: offset * span / D.
	rsa_divider #(
		.DIVIDEND_W (PROD_W),
		.DIVISOR_W  (CHANNEL_BITS),
		.QUOT_W     (CHANNEL_BITS),
		.SIDE_W     (MSIDE)
	) u_mdiv (
		.clk       (clk),
		.en        (en),
		.dividend  (span_prod),
		.divisor   (span_ms.side.d),
		.side_in   (span_ms),
		.quotient  (mquot),
		.remainder (mrem),
		.side_out  (mside_vec)
	);

	assign mside = mside_vec;

	// Final selection: put min, middle and max back on their channels, or take the blend.
	always_comb begin
		mid_sum = {1'b0, mside.nmin} + {1'b0, mquot};
		mid_new = mid_sum[CHANNEL_BITS] ? chan_t'(CH_MAX) : mid_sum[CHANNEL_BITS-1:0];
		case (mside.side.mode)
			MODE_POS: begin
				out_d.red_out   = place(CH_RED, mside.side.srt, mside.nmin, mid_new, mside.nmax);
				out_d.green_out = place(CH_GREEN, mside.side.srt, mside.nmin, mid_new,
					mside.nmax);
				out_d.blue_out  = place(CH_BLUE, mside.side.srt, mside.nmin, mid_new, mside.nmax);
			end
			MODE_NEG: begin
				out_d.red_out   = mside.side.neg_red;
				out_d.green_out = mside.side.neg_green;
				out_d.blue_out  = mside.side.neg_blue;
			end
			default: begin
				out_d.red_out   = mside.side.red;
				out_d.green_out = mside.side.green;
				out_d.blue_out  = mside.side.blue;
			end
		endcase
	end

	// Output buffer: res_q is shown on res, spare_q catches one result while res is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
			spare_v_q <= 1'b0;
		end else if (!res_valid || pop) begin
			res_valid <= spare_v_q || push;
			spare_v_q <= 1'b0;
		end else if (push) begin
			spare_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!res_valid || pop) begin
			res_q <= spare_v_q ? spare_q : out_d;
		end else if (push) begin
			spare_q <= out_d;
		end
	end

	assign res = res_q;

	// The input is held off only while a result is waiting in the output register.
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> res_valid)
		else $error("input stalled with no result waiting");

	// A blended channel stays between the pixel's min and max.
	a_neg_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[FRONT_STAGES-1] && fr.side.mode == MODE_NEG) |->
		(fr.side.neg_red >= fr.side.srt.mn && fr.side.neg_red <= fr.side.srt.mx &&
		fr.side.neg_green >= fr.side.srt.mn && fr.side.neg_green <= fr.side.srt.mx &&
		fr.side.neg_blue >= fr.side.srt.mn && fr.side.neg_blue <= fr.side.srt.mx))
		else $error("blended channel outside the pixel's range");

	// The new span is ordered and the rescaled middle offset fits inside it.
	a_span_fit: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[NST-1] && mside.side.mode == MODE_POS) |->
		(mside.nmin <= mside.nmax && mquot <= chan_t'(mside.nmax - mside.nmin)))
		else $error("middle channel rescale outside the new span");

endmodule

@@ sim/tb_rgb_saturation_adjust.sv @@
// Self-checking testbench for rgb_saturation_adjust: a queue-fed pixel driver, a result monitor
// and a predictor of the saturation arithmetic, run through many register settings.
// Depends on rsa_pkg and the rgb_saturation_adjust RTL.
module tb_rgb_saturation_adjust;
	timeunit 1ns;
	timeprecision 1ps;

	import rsa_pkg::*;

	localparam int PIPE_LATENCY   = 2 * CHANNEL_BITS + 8;
	localparam int LONG_STALL     = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_PIXELS   = 125;
	localparam int PHASE_COUNT    = 12;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  pix_valid = 1'b0;
	logic                  pix_ready;
	pix_in_t               pix       = '0;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	pix_out_t              res;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_idx_t              cfg_index = CFG_SATURATION;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Pixels waiting to be offered and adjusted pixels still due from the block.
	pix_in_t  pixel_queue[$];
	pix_out_t expected_pixels[$];
	pix_out_t want;

	// Local copy of the configuration registers.
	int sat_pct = 0;
	bit mask_on = 1'b0;

	int  send_idle_pct = 6;
	int  recv_idle_pct = 47;
	bit  stall_armed   = 1'b0;
	int  stall_left    = 0;
	logic pix_fired    = 1'b0;
	int  idle_cycles   = 0;
	int  fail_count    = 0;

	rgb_saturation_adjust dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(string msg);
		fail_count++;
		if (fail_count <= 100) begin
			$display("%0t ns: %s", $realtime, msg);
		end
	endtask

	function automatic longint clamp_channel(longint v);
		if (v < 0) return 0;
		if (v > CH_MAX) return CH_MAX;
		return v;
	endfunction

	// Works out the adjusted pixel under the current register values.
	function automatic pix_out_t predict_pixel(pix_in_t px);
		longint   c[3];
		longint   p, q, sn, sd, d, mn, mx, nmin, nmax, m;
		int       lo, md, hi;
		pix_out_t o;
		c[0] = px.red_in;
		c[1] = px.green_in;
		c[2] = px.blue_in;
		p = sat_pct;
		if (p > 100) p = 100;
		if (p < -100) p = -100;
		if ((!mask_on || px.in_region) && p != 0) begin
			// Red and green first; blue displaces an end only when strictly beyond it.
			if (c[0] > c[1]) begin
				hi = 0;
				lo = 1;
			end else begin
				hi = 1;
				lo = 0;
			end
			if (c[2] > c[hi]) begin
				md = hi;
				hi = 2;
			end else if (c[2] < c[lo]) begin
				md = lo;
				lo = 2;
			end else begin
				md = 2;
			end
			mn = c[lo];
			mx = c[hi];
			d  = mx - mn;
			if (p > 0 && d != 0) begin
				// Full saturation uses a spread ratio of 9999 rather than an infinite one.
				if (p >= 100) begin
					sn = 9999;
					sd = 1;
				end else begin
					sn = p;
					sd = 100 - p;
				end
				nmin = (2 * sd * mn - d * sn) / (2 * sd);
				nmax = (2 * sd * mx + d * sn) / (2 * sd);
				if (nmin < 0) begin
					nmin = 0;
					nmax = mx + mn;
				end
				if (nmax > CH_MAX) begin
					nmax = CH_MAX;
					nmin = mn - (CH_MAX - mx);
				end
				nmin = clamp_channel(nmin);
				nmax = clamp_channel(nmax);
				if (nmax < nmin) nmax = nmin;
				c[md] = clamp_channel(nmin + ((c[md] - mn) * (nmax - nmin)) / d);
				c[lo] = nmin;
				c[hi] = nmax;
			end else if (p < 0) begin
				// Desaturation blends every channel towards the mid-point of the ends.
				q = -p;
				m = (mx + mn) / 2;
				for (int i = 0; i < 3; i++) begin
					c[i] = clamp_channel((c[i] * (100 - q) + m * q) / 100);
				end
			end
		end
		o.red_out   = chan_t'(c[0]);
		o.green_out = chan_t'(c[1]);
		o.blue_out  = chan_t'(c[2]);
		return o;
	endfunction

	// Random pixels, biased towards grey, tied and extreme channel values.
	function automatic pix_in_t random_pixel();
		pix_in_t px;
		px = pix_in_t'($urandom);
		case ($urandom_range(7))
			0: begin
				px.green_in = px.red_in;
				px.blue_in  = px.red_in;
			end
			1: px.green_in = px.red_in;
			2: px.blue_in = $urandom_range(1) ? px.red_in : px.green_in;
			3: begin
				px.red_in   = $urandom_range(1) ? chan_t'(CH_MAX - $urandom_range(1))
				                                : chan_t'($urandom_range(1));
				px.blue_in  = $urandom_range(1) ? chan_t'(CH_MAX - $urandom_range(1))
				                                : chan_t'($urandom_range(1));
			end
			4: begin
				px.green_in = px.red_in ^ chan_t'($urandom_range(3));
				px.blue_in  = px.red_in ^ chan_t'($urandom_range(3));
			end
			default: ;
		endcase
		return px;
	endfunction

	// Pixel driver: a new pixel is offered only once the previous one has transferred.
	always @(negedge clk) begin
		if (!pix_valid || pix_fired) begin
			if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				pix       <= pixel_queue.pop_front();
				pix_valid <= 1'b1;
			end else begin
				pix_valid <= 1'b0;
			end
		end
	end

	// Result acceptor, with random back-pressure and an occasional long hold-off.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			res_ready  <= 1'b0;
		end else if (stall_armed) begin
			stall_armed = 1'b0;
			stall_left <= LONG_STALL;
			res_ready  <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Prediction on each pixel transfer, checking on each result transfer, and the watchdog.
	always @(posedge clk) begin
		if (pix_valid && pix_ready) begin
			expected_pixels.push_back(predict_pixel(pix));
		end
		pix_fired <= pix_valid && pix_ready;
		if (res_valid && res_ready) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch($sformatf("result %h arrived with nothing expected", res));
			end else begin
				want = expected_pixels.pop_front();
				if (res.red_out !== want.red_out)
					report_mismatch($sformatf("red_out %0d, expected %0d",
						res.red_out, want.red_out));
				if (res.green_out !== want.green_out)
					report_mismatch($sformatf("green_out %0d, expected %0d",
						res.green_out, want.green_out));
				if (res.blue_out !== want.blue_out)
					report_mismatch($sformatf("blue_out %0d, expected %0d",
						res.blue_out, want.blue_out));
			end
		end
		if ((pix_valid && pix_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("rgb_saturation_adjust regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Waits until every pixel has been offered, transferred and answered.
	task automatic wait_drained();
		do @(posedge clk);
		while (pixel_queue.size() != 0 || pix_valid || expected_pixels.size() != 0);
	endtask

	// One transfer on the configuration channel, mirrored into the local register copy.
	task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_SATURATION: sat_pct = int'($signed(data));
			CFG_MASK:       mask_on = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_registers(int sat, bit mask);
		wait_drained();
		write_register(CFG_SATURATION, CFG_DATA_W'(sat));
		write_register(CFG_MASK, {7'($urandom), mask});
		@(posedge clk);
	endtask

	initial begin
		pix_in_t directed[10];
		int      phase_sat[PHASE_COUNT];

		directed = '{
			'{8'd0,   8'd0,   8'd0,   1'b1},
			'{8'd255, 8'd255, 8'd255, 1'b0},
			'{8'd255, 8'd0,   8'd0,   1'b1},
			'{8'd0,   8'd255, 8'd255, 1'b1},
			'{8'd200, 8'd10,  8'd10,  1'b1},
			'{8'd10,  8'd10,  8'd200, 1'b1},
			'{8'd100, 8'd200, 8'd200, 1'b0},
			'{8'd0,   8'd1,   8'd255, 1'b1},
			'{8'd128, 8'd64,  8'd192, 1'b1},
			'{8'd254, 8'd1,   8'd127, 1'b0}
		};
		phase_sat = '{100, -100, 50, 127, -128, 1, -1, 99, 101, -101, 0, 0};
		phase_sat[PHASE_COUNT-1] = int'($urandom_range(255)) - 128;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed pixels: pass-through straight after reset, then both saturation extremes.
		for (int i = 0; i < 4; i++) pixel_queue.push_back(directed[i]);
		set_registers(100, 1'b0);
		foreach (directed[i]) pixel_queue.push_back(directed[i]);
		set_registers(-128, 1'b1);
		foreach (directed[i]) pixel_queue.push_back(directed[i]);

		// Random pixels under a series of register settings and idling patterns.
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			set_registers(phase_sat[ph], ph[0]);
			if (ph < 4) begin
				send_idle_pct = 6;
				recv_idle_pct = 47;
			end else if (ph < 8) begin
				send_idle_pct = 47;
				recv_idle_pct = 6;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int i = 0; i < PHASE_PIXELS; i++) pixel_queue.push_back(random_pixel());
			// Hold results off long enough for the pipeline to fill and stall its input.
			if (ph == 2) stall_armed = 1'b1;
		end

		wait_drained();
		repeat (2 * PIPE_LATENCY) @(posedge clk);
		if (expected_pixels.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));
		if (fail_count == 0) begin
			$display("rgb_saturation_adjust regression: pass");
		end else begin
			$display("rgb_saturation_adjust regression: fail");
		end
		$finish;
	end

endmodule
